FILE: rtl/tdpid_pkg.sv
package tdpid_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INTEGRAL_WEIGHT_DEF = 1;
  localparam int DERIV_WEIGHT_DEF = 1;
  localparam int DERIV_SETPOINT_WEIGHT_DEF = 0;

  localparam int ACC_W = 48;
  localparam int DATA_W = 32;
  localparam int LIM_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [LIM_W-1:0] lim_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AW_RECIP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PD_FB_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SP_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd7;

  localparam data_t PROP_GAIN_RST = 32'sd66;
  localparam data_t AW_RECIP_RST = 32'sd65536000;
  localparam data_t INT_GAIN_RST = 32'sd0;
  localparam data_t PD_FB_GAIN_RST = 32'sd0;
  localparam data_t DERIV_GAIN_RST = 32'sd0;
  localparam data_t SP_WEIGHT_RST = 32'sd65536;
  localparam lim_t UPPER_RST = 16'sd32767;
  localparam lim_t LOWER_RST = -16'sd32768;

  // filter constant and the reciprocal of one plus it, Q32
  localparam logic [63:0] KF_Q32 = 64'd26893957306;
  localparam logic [63:0] KF_RECIP_Q32 = 64'd591451743;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic data_t from_q32(input int frac, input logic [63:0] q);
    logic [63:0] t;
    begin
      t = (q + (64'd1 << (31 - frac))) >> (32 - frac);
      return t[DATA_W-1:0];
    end
  endfunction

  function automatic acc_t sat48(input logic signed [ACC_W:0] x);
    begin
      if (x[ACC_W] != x[ACC_W-1]) begin
        return x[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return x[ACC_W-1:0];
    end
  endfunction

  function automatic acc_t sat_add(input acc_t a, input acc_t b);
    begin
      return sat48({a[ACC_W-1], a} + {b[ACC_W-1], b});
    end
  endfunction

  function automatic acc_t sat_sub(input acc_t a, input acc_t b);
    begin
      return sat48({a[ACC_W-1], a} - {b[ACC_W-1], b});
    end
  endfunction

  function automatic acc_t ext32(input data_t x);
    begin
      return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
    end
  endfunction

  function automatic data_t sat32(input acc_t x);
    begin
      if (x[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){x[ACC_W-1]}}) begin
        return x[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/tdpid_if.sv
interface tdpid_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measurement;
  logic follow_model;
  logic signed [31:0] model_reference;

  modport source (output valid, setpoint, measurement, follow_model, model_reference,
                  input ready);
  modport sink (input valid, setpoint, measurement, follow_model, model_reference,
                output ready);
endinterface

interface tdpid_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] drive;
  logic signed [31:0] unclamped_drive;
  logic signed [31:0] tracking_error;

  modport source (output valid, drive, unclamped_drive, tracking_error, input ready);
  modport sink (input valid, drive, unclamped_drive, tracking_error, output ready);
endinterface

FILE: rtl/tdpid_mul.sv
module tdpid_mul #(
  parameter int FRAC_BITS = tdpid_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  tdpid_pkg::acc_t a,
  input  tdpid_pkg::data_t b,
  output tdpid_pkg::acc_t p,
  output tdpid_pkg::mul_stat_t stat
);
  import tdpid_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);
  localparam int PROD_W = ACC_W + DATA_W;

  logic [ACC_W-1:0] ma;
  logic [DATA_W-1:0] mb;
  logic [ACC_W:0] hi;
  logic [DATA_W-1:0] lo;
  logic [CNT_W-1:0] cnt;
  logic neg;
  logic busy;
  logic done;

  logic [ACC_W:0] sum;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-2:0] mag;
  logic ovf;

  // one multiplier bit per cycle, LSB first; partial sum shifts right into lo
  assign sum = hi + {1'b0, (mb[0] ? ma : {ACC_W{1'b0}})};
  assign prod = {hi[ACC_W-1:0], lo};
  assign ovf = |prod[PROD_W-1:FRAC_BITS+ACC_W-1];
  assign mag = ovf ? {(ACC_W-1){1'b1}} : prod[FRAC_BITS+ACC_W-2:FRAC_BITS];
  assign p = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(DATA_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma <= a[ACC_W-1] ? ACC_W'(-a) : a;
      mb <= b[DATA_W-1] ? DATA_W'(-b) : b;
      neg <= a[ACC_W-1] ^ b[DATA_W-1];
      // rounding offset lands at weight 2^(FRAC_BITS-1) after all shifts
      hi <= (ACC_W+1)'(1) << (FRAC_BITS - 1);
      lo <= '0;
      cnt <= '0;
    end else if (busy) begin
      hi <= {1'b0, sum[ACC_W:1]};
      lo <= {sum[0], lo[DATA_W-1:1]};
      mb <= mb >> 1;
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

FILE: rtl/two_dof_pid_antiwindup_top.sv
// A sample word is accepted only while idle, so each is finished before the next is taken.
// Each sample runs 11 products through one bit-serial multiplier, each product being
// an operand load, 32 shift-add steps and done; then the result word is registered.
// The finish state waits until the output register is free; a result waits in the
// output register while the next sample is already being computed.
// Reset (rst, synchronous): registers take their defaults, controller state zero.
module two_dof_pid_antiwindup_top #(
  parameter int FRAC_BITS = tdpid_pkg::FRAC_BITS_DEF,
  parameter int INTEGRAL_WEIGHT = tdpid_pkg::INTEGRAL_WEIGHT_DEF,
  parameter int DERIV_WEIGHT = tdpid_pkg::DERIV_WEIGHT_DEF,
  parameter int DERIV_SETPOINT_WEIGHT = tdpid_pkg::DERIV_SETPOINT_WEIGHT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tdpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdpid_pkg::DATA_W-1:0] cfg_data,
  tdpid_in_if.sink sample,
  tdpid_out_if.source result
);
  import tdpid_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RUN = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  localparam logic [3:0] STEP_AW = 4'd0;
  localparam logic [3:0] STEP_DPREV = 4'd1;
  localparam logic [3:0] STEP_DERR = 4'd2;
  localparam logic [3:0] STEP_IPREV = 4'd3;
  localparam logic [3:0] STEP_PDPREV = 4'd4;
  localparam logic [3:0] STEP_SPW = 4'd5;
  localparam logic [3:0] STEP_DNEW = 4'd6;
  localparam logic [3:0] STEP_FILT = 4'd7;
  localparam logic [3:0] STEP_INEW = 4'd8;
  localparam logic [3:0] STEP_PDNEW = 4'd9;
  localparam logic [3:0] STEP_OUT = 4'd10;

  localparam data_t KF_MINUS = from_q32(FRAC_BITS, KF_Q32) - (DATA_W'(1) << FRAC_BITS);
  localparam data_t KF_RECIP = from_q32(FRAC_BITS, KF_RECIP_Q32);

  data_t prop_gain, aw_recip, int_gain, pd_fb_gain, deriv_gain, sp_weight;
  lim_t upper, lower;

  acc_t int_term, deriv_term, last_int_err, last_deriv_err, last_pd_sum, last_raw;
  data_t last_drive;

  data_t r_s, y_s, ym;
  acc_t eu, ua, yf, ud, ui, ep, ei, ed, upd, vv;

  logic [2:0] state;
  logic [3:0] step;
  logic res_valid;

  acc_t mul_a, mul_p, et1, et;
  data_t mul_b;
  logic mul_start;
  mul_stat_t mul_stat;

  acc_t u48, hi48, lo48, clamp_u;
  data_t hi32, lo32;
  logic signed [DATA_W:0] track;
  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= PROP_GAIN_RST;
      aw_recip <= AW_RECIP_RST;
      int_gain <= INT_GAIN_RST;
      pd_fb_gain <= PD_FB_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
      sp_weight <= SP_WEIGHT_RST;
      upper <= UPPER_RST;
      lower <= LOWER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN: prop_gain <= cfg_data;
        CFG_AW_RECIP: aw_recip <= cfg_data;
        CFG_INT_GAIN: int_gain <= cfg_data;
        CFG_PD_FB_GAIN: pd_fb_gain <= cfg_data;
        CFG_DERIV_GAIN: deriv_gain <= cfg_data;
        CFG_SP_WEIGHT: sp_weight <= cfg_data;
        CFG_UPPER: upper <= cfg_data[LIM_W-1:0];
        CFG_LOWER: lower <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign et1 = sat_add(ep, (INTEGRAL_WEIGHT != 0) ? ui : '0);
  assign et = sat_add(et1, (DERIV_WEIGHT != 0) ? ud : '0);

  always_comb begin
    case (step)
      STEP_AW: begin mul_a = eu; mul_b = aw_recip; end
      STEP_DPREV: begin mul_a = deriv_term; mul_b = KF_MINUS; end
      STEP_DERR: begin mul_a = last_deriv_err; mul_b = deriv_gain; end
      STEP_IPREV: begin mul_a = last_int_err; mul_b = int_gain; end
      STEP_PDPREV: begin mul_a = last_pd_sum; mul_b = pd_fb_gain; end
      STEP_SPW: begin mul_a = ext32(ym); mul_b = sp_weight; end
      STEP_DNEW: begin mul_a = ed; mul_b = deriv_gain; end
      STEP_FILT: begin mul_a = ud; mul_b = KF_RECIP; end
      STEP_INEW: begin mul_a = ei; mul_b = int_gain; end
      STEP_PDNEW: begin mul_a = upd; mul_b = pd_fb_gain; end
      STEP_OUT: begin mul_a = et; mul_b = prop_gain; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_start = (state == ST_LOAD);

  tdpid_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a),
    .b(mul_b),
    .p(mul_p),
    .stat(mul_stat)
  );

  // output clamp; a crossed pair of limits leaves the lower limit
  assign hi48 = ext32(DATA_W'($signed(upper))) <<< FRAC_BITS;
  assign lo48 = ext32(DATA_W'($signed(lower))) <<< FRAC_BITS;
  assign hi32 = sat32(hi48);
  assign lo32 = sat32(lo48);
  assign u48 = sat_sub(vv, ua);
  always_comb begin
    clamp_u = u48;
    if (clamp_u > ext32(hi32)) begin
      clamp_u = ext32(hi32);
    end
    if (clamp_u < ext32(lo32)) begin
      clamp_u = ext32(lo32);
    end
  end
  assign track = {r_s[DATA_W-1], r_s} - {y_s[DATA_W-1], y_s};

  assign out_free = !res_valid || result.ready;
  assign sample.ready = (state == ST_IDLE);
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= STEP_AW;
      int_term <= '0;
      deriv_term <= '0;
      last_int_err <= '0;
      last_deriv_err <= '0;
      last_pd_sum <= '0;
      last_raw <= '0;
      last_drive <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            step <= STEP_AW;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (mul_stat.done) begin
            if (step == STEP_OUT) begin
              state <= ST_FINISH;
            end else begin
              step <= step + 4'd1;
              state <= ST_LOAD;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            int_term <= ui;
            deriv_term <= ud;
            last_int_err <= ei;
            last_deriv_err <= ed;
            last_pd_sum <= upd;
            last_raw <= vv;
            last_drive <= clamp_u[DATA_W-1:0];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample.valid) begin
      r_s <= sample.setpoint;
      y_s <= sample.measurement;
      ym <= sample.follow_model ? sample.model_reference : sample.setpoint;
      eu <= sat_sub(ext32(last_drive), last_raw);
    end
    if (state == ST_RUN && mul_stat.done) begin
      case (step)
        STEP_AW: begin
          ua <= mul_p;
          yf <= sat_add(ext32(y_s), mul_p);
        end
        STEP_DPREV: begin
          ud <= mul_p;
          ei <= sat_add(sat_sub(ext32(ym), yf), eu);
          ed <= sat_sub((DERIV_SETPOINT_WEIGHT != 0) ? ext32(ym) : '0, yf);
        end
        STEP_DERR: ud <= sat_sub(ud, mul_p);
        STEP_IPREV: ui <= sat_add(int_term, mul_p);
        STEP_PDPREV: ui <= sat_sub(ui, mul_p);
        STEP_SPW: ep <= sat_sub(mul_p, yf);
        STEP_DNEW: ud <= sat_add(ud, mul_p);
        STEP_FILT: begin
          ud <= mul_p;
          upd <= sat_add(ep, mul_p);
        end
        STEP_INEW: ui <= sat_add(ui, mul_p);
        STEP_PDNEW: ui <= sat_add(sat_sub(ui, ua), mul_p);
        STEP_OUT: vv <= mul_p;
        default: ;
      endcase
    end
    if (state == ST_FINISH && out_free) begin
      result.drive <= clamp_u[DATA_W-1:0];
      result.unclamped_drive <= sat32(vv);
      result.tracking_error <= sat32(ACC_W'(track));
    end
  end

`ifndef SYNTHESIS
  a_drive_in_limits: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (lo32 <= hi32)) |-> (result.drive <= hi32 && result.drive >= lo32))
    else $error("drive outside limits");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_one_sample_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("second sample taken during computation");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_RUN))
    else $error("product finished outside run state");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tdpid_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint ONE = 64'sd1 <<< FRAC_BITS_DEF;
  localparam logic [63:0] MAG48 = (64'd1 << 47) - 64'd1;

  typedef struct {
    data_t drive;
    data_t unclamped_drive;
    data_t tracking_error;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  tdpid_in_if sample();
  tdpid_out_if result();

  two_dof_pid_antiwindup_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample),
    .result(result)
  );

  always #10 clk = ~clk;

  // controller settings and state as seen by the predictor
  longint reg_val[8];
  longint integ, deriv, last_ei, last_ed, last_pd, last_raw, last_u;

  drive_word_t pending_q[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_go = 1'b0;    // long receiver hold-off request
  int stall_left = 0;

  function automatic longint clip(longint x, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  // exact product, rounded half away from zero, saturated to 48 bits
  function automatic longint mul_q(longint a, longint b);
    logic neg;
    logic [63:0] ma, mb, ah, al, hp, r;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? 64'(-a) : 64'(a);
    mb = b < 0 ? 64'(-b) : 64'(b);
    ah = ma >> 24;
    al = ma & 64'hFF_FFFF;
    hp = ah * mb;
    if (hp > (MAG48 >> (24 - FRAC_BITS_DEF))) begin
      r = MAG48;
    end else begin
      r = (hp << (24 - FRAC_BITS_DEF)) +
          ((al * mb + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF);
      if (r > MAG48) r = MAG48;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic drive_word_t next_drive(data_t r_in, data_t y_in, logic fm,
                                             data_t m_in);
    longint r, y, ym, kfm, kfr, eu, ua, yf, ud, ui, ep, ei, ed, upd, et, v, u, hi, lo;
    drive_word_t w;
    r = r_in;
    y = y_in;
    ym = fm ? longint'(m_in) : r;
    kfm = longint'((KF_Q32 + (64'd1 << (31 - FRAC_BITS_DEF))) >> (32 - FRAC_BITS_DEF)) - ONE;
    kfr = longint'((KF_RECIP_Q32 + (64'd1 << (31 - FRAC_BITS_DEF))) >> (32 - FRAC_BITS_DEF));

    eu = clip(last_u - last_raw, 48);
    ua = mul_q(eu, reg_val[CFG_AW_RECIP]);
    yf = clip(y + ua, 48);

    ud = clip(mul_q(deriv, kfm) - mul_q(last_ed, reg_val[CFG_DERIV_GAIN]), 48);
    ui = clip(integ + mul_q(last_ei, reg_val[CFG_INT_GAIN]), 48);
    ui = clip(ui - mul_q(last_pd, reg_val[CFG_PD_FB_GAIN]), 48);

    ep = clip(mul_q(ym, reg_val[CFG_SP_WEIGHT]) - yf, 48);
    ei = clip(clip(ym - yf, 48) + eu, 48);
    ed = clip(longint'(DERIV_SETPOINT_WEIGHT_DEF) * ym - yf, 48);

    ud = clip(ud + mul_q(ed, reg_val[CFG_DERIV_GAIN]), 48);
    ud = mul_q(ud, kfr);
    upd = clip(ep + ud, 48);

    ui = clip(ui + mul_q(ei, reg_val[CFG_INT_GAIN]), 48);
    ui = clip(ui - ua, 48);
    ui = clip(ui + mul_q(upd, reg_val[CFG_PD_FB_GAIN]), 48);

    et = clip(ep + longint'(INTEGRAL_WEIGHT_DEF) * ui, 48);
    et = clip(et + longint'(DERIV_WEIGHT_DEF) * ud, 48);
    v = mul_q(et, reg_val[CFG_PROP_GAIN]);
    u = clip(v - ua, 48);

    // upper clamp first, so crossed limits leave the lower one
    hi = clip(reg_val[CFG_UPPER] * ONE, 32);
    lo = clip(reg_val[CFG_LOWER] * ONE, 32);
    if (u > hi) u = hi;
    if (u < lo) u = lo;
    u = clip(u, 32);

    integ = ui;
    deriv = ud;
    last_ei = ei;
    last_ed = ed;
    last_pd = upd;
    last_raw = v;
    last_u = u;

    w.drive = data_t'(u);
    w.unclamped_drive = data_t'(clip(v, 32));
    w.tracking_error = data_t'(clip(r - y, 32));
    return w;
  endfunction

  task automatic send_sample(data_t r, data_t y, logic fm, data_t m);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.setpoint <= r;
    sample.measurement <= y;
    sample.follow_model <= fm;
    sample.model_reference <= m;
    do @(posedge clk); while (!sample.ready);
    pending_q.push_back(next_drive(r, y, fm, m));
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_UPPER || idx == CFG_LOWER) begin
      reg_val[idx] = longint'($signed(d[LIM_W-1:0]));
    end else begin
      reg_val[idx] = longint'($signed(d));
    end
  endtask

  // Q16.16 operand: mostly modest values, sometimes the full range or an edge
  function automatic data_t rand_q(int span);
    case ($urandom_range(0, 9))
      0: return data_t'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return 32'sd0;
      default: return data_t'(longint'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic data_t rand_limit();
    logic [15:0] l;
    case ($urandom_range(0, 5))
      0: l = 16'h7FFF;
      1: l = 16'h8000;
      default: l = 16'($urandom_range(0, 400)) - 16'd200;
    endcase
    return data_t'({$urandom} & 32'hFFFF_0000) | data_t'(l);
  endfunction

  task automatic random_settings();
    data_t a, b;
    write_reg(CFG_PROP_GAIN, rand_q(1 << 19));
    write_reg(CFG_AW_RECIP, rand_q(1 << 17));
    write_reg(CFG_INT_GAIN, rand_q(1 << 15));
    write_reg(CFG_PD_FB_GAIN, rand_q(1 << 15));
    write_reg(CFG_DERIV_GAIN, rand_q(1 << 17));
    write_reg(CFG_SP_WEIGHT, rand_q(1 << 17));
    a = rand_limit();
    b = rand_limit();
    // usually ordered limits, sometimes crossed
    if ($urandom_range(0, 3) != 0 && $signed(a[LIM_W-1:0]) < $signed(b[LIM_W-1:0])) begin
      write_reg(CFG_UPPER, b);
      write_reg(CFG_LOWER, a);
    end else begin
      write_reg(CFG_UPPER, a);
      write_reg(CFG_LOWER, b);
    end
  endtask

  task automatic random_samples(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_sample(rand_q(100 << 16), rand_q(100 << 16), 1'($urandom_range(0, 1)),
                  rand_q(100 << 16));
    end
    quiet = 1'b0;
  endtask

  task automatic test_field_extremes();
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 32'sd0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'sh7FFF_FFFF);
    send_sample(32'sd0, 32'sd0, 1'b1, 32'sh8000_0000);
    send_sample(32'sd65536, -32'sd65536, 1'b1, 32'sh7FFF_FFFF);
    send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 32'shAAAA_AAAA);
    send_sample(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 32'sh5555_5555);
    drain();
  endtask

  task automatic test_crossed_limits();
    write_reg(CFG_PROP_GAIN, 32'sd131072);
    write_reg(CFG_UPPER, 32'shFFFF_FFF6);
    write_reg(CFG_LOWER, 32'sd10);
    send_sample(32'sd655360, 32'sd0, 1'b0, 32'sd0);
    send_sample(-32'sd655360, 32'sd0, 1'b0, 32'sd0);
    drain();
  endtask

  task automatic test_limit_extremes();
    write_reg(CFG_UPPER, 32'sd32767);
    write_reg(CFG_LOWER, 32'shFFFF_8000);
    write_reg(CFG_INT_GAIN, 32'sd6554);
    write_reg(CFG_PD_FB_GAIN, 32'sd98304);
    write_reg(CFG_DERIV_GAIN, 32'sd32768);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 32'sd0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'sd0);
    drain();
    write_reg(CFG_UPPER, 32'sd0);
    write_reg(CFG_LOWER, 32'sd0);
    send_sample(32'sd1000, 32'sd0, 1'b1, 32'sd5000);
    drain();
  endtask

  task automatic test_gain_extremes();
    write_reg(CFG_UPPER, 32'sd32767);
    write_reg(CFG_LOWER, 32'sh8000);
    write_reg(CFG_PROP_GAIN, 32'sh7FFF_FFFF);
    write_reg(CFG_AW_RECIP, 32'sh8000_0000);
    write_reg(CFG_INT_GAIN, 32'sh7FFF_FFFF);
    write_reg(CFG_PD_FB_GAIN, 32'sh8000_0000);
    write_reg(CFG_DERIV_GAIN, 32'sh7FFF_FFFF);
    write_reg(CFG_SP_WEIGHT, 32'sh8000_0000);
    send_sample(32'sd65536, 32'sd0, 1'b0, 32'sd0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF);
    send_sample(32'sd0, 32'sd0, 1'b0, 32'sd0);
    drain();
    write_reg(CFG_PROP_GAIN, 32'sd0);
    write_reg(CFG_SP_WEIGHT, 32'sd0);
    send_sample(32'sd1, -32'sd1, 1'b1, 32'sd3);
    drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      random_settings();
      random_samples(230);
      drain();
    end
  endtask

  task automatic test_output_holdoff();
    random_settings();
    quiet = 1'b1;
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_sample(rand_q(100 << 16), rand_q(100 << 16), 1'($urandom_range(0, 1)),
                  rand_q(100 << 16));
    end
    quiet = 1'b0;
    random_samples(60);
    drain();
  endtask

  // long receiver stall, counted here
  initial begin
    forever begin
      wait (hold_go);
      repeat (3000) @(posedge clk);
      hold_go = 1'b0;
    end
  end

  always @(posedge clk) begin
    int stall_n;
    if (rst) begin
      result.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result.valid && result.ready) begin
        stall_n = quiet ? 0 : $urandom_range(0, 16);
      end else begin
        stall_n = stall_left > 0 ? stall_left - 1 : 0;
      end
      stall_left <= stall_n;
      result.ready <= (stall_n == 0) && !hold_go;
    end
  end

  always @(posedge clk) begin
    drive_word_t w;
    if (!rst && result.valid && result.ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected drive word %0d", result.drive);
      end else begin
        w = pending_q.pop_front();
        if (result.drive !== w.drive || result.unclamped_drive !== w.unclamped_drive ||
            result.tracking_error !== w.tracking_error) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch drive exp %0d got %0d, raw exp %0d got %0d, err exp %0d got %0d",
                     w.drive, result.drive, w.unclamped_drive, result.unclamped_drive,
                     w.tracking_error, result.tracking_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sample.valid = 1'b0;
    sample.setpoint = '0;
    sample.measurement = '0;
    sample.follow_model = 1'b0;
    sample.model_reference = '0;
    reg_val[CFG_PROP_GAIN] = PROP_GAIN_RST;
    reg_val[CFG_AW_RECIP] = AW_RECIP_RST;
    reg_val[CFG_INT_GAIN] = INT_GAIN_RST;
    reg_val[CFG_PD_FB_GAIN] = PD_FB_GAIN_RST;
    reg_val[CFG_DERIV_GAIN] = DERIV_GAIN_RST;
    reg_val[CFG_SP_WEIGHT] = SP_WEIGHT_RST;
    reg_val[CFG_UPPER] = UPPER_RST;
    reg_val[CFG_LOWER] = LOWER_RST;
    {integ, deriv, last_ei, last_ed, last_pd, last_raw, last_u} = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_crossed_limits();
    test_limit_extremes();
    test_gain_extremes();
    test_random_phases();
    test_output_holdoff();

    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
